FILE: hdl/disk_image_sector_offset_core_macros.svh
// Assertion macros for the sector offset checker.
`ifndef DISK_IMAGE_SECTOR_OFFSET_CORE_MACROS_SVH
`define DISK_IMAGE_SECTOR_OFFSET_CORE_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define DISO_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define DISO_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/diso_pkg.sv
// Shared types, constants and lookup functions for the sector offset core.
`timescale 1ns / 1ps
`default_nettype none

package diso_pkg;

  // Image kind codes held in the configuration register.
  localparam logic [2:0] MEDIA_ZONED_SINGLE = 3'd0;
  localparam logic [2:0] MEDIA_ZONED_DOUBLE = 3'd1;
  localparam logic [2:0] MEDIA_LINEAR_DISK  = 3'd2;
  localparam logic [2:0] MEDIA_HARD_DISK    = 3'd3;
  localparam logic [2:0] MEDIA_SECTORLESS   = 3'd4;

  // Geometry constants.
  localparam int unsigned SIDE_TRACKS     = 35;
  localparam int unsigned SIDE_TWO_BASE   = 174848;
  localparam int unsigned D81_TRACK_BYTES = 10240;
  localparam int unsigned SECTOR_BYTES    = 256;

  // Start offset of tracks 1 to 35 of one side, stored at track - 1.
  localparam logic [17:0] ZONE_START [SIDE_TRACKS] = '{
    18'h00000, 18'h01500, 18'h02a00, 18'h03f00, 18'h05400, 18'h06900, 18'h07e00,
    18'h09300, 18'h0a800, 18'h0bd00, 18'h0d200, 18'h0e700, 18'h0fc00, 18'h11100,
    18'h12600, 18'h13b00, 18'h15000, 18'h16500, 18'h17800, 18'h18b00, 18'h19e00,
    18'h1b100, 18'h1c400, 18'h1d700, 18'h1ea00, 18'h1fc00, 18'h20e00, 18'h22000,
    18'h23200, 18'h24400, 18'h25600, 18'h26700, 18'h27800, 18'h28900, 18'h29a00
  };

  // One lookup request.
  typedef struct packed {
    logic [7:0] track_number;
    logic [7:0] sector_number;
  } req_t;

  // One lookup result.
  typedef struct packed {
    logic        offset_valid;
    logic [23:0] byte_offset;
  } result_t;

  // Track start within one side; entries past the table read as zero.
  function automatic logic [17:0] zone_start(input logic [5:0] idx);
    logic [17:0] v;
    v = '0;
    if (idx < 6'(SIDE_TRACKS)) begin
      v = ZONE_START[idx];
    end
    return v;
  endfunction

  // Sectors on one side's track, for tracks 1 to 35.
  function automatic logic [4:0] zone_sectors(input logic [5:0] trk);
    logic [4:0] n;
    if (trk <= 6'd17) begin
      n = 5'd21;
    end else if (trk <= 6'd24) begin
      n = 5'd19;
    end else if (trk <= 6'd30) begin
      n = 5'd18;
    end else begin
      n = 5'd17;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/diso_calc.sv
// Combinational track and sector to byte offset resolver.
`timescale 1ns / 1ps
`default_nettype none

module diso_calc (
  input  wire diso_pkg::req_t    req,
  input  wire logic [2:0]        media_kind,
  output diso_pkg::result_t      res
);

  logic [7:0]  trk;
  logic [7:0]  sec;
  logic [7:0]  trk_m1;
  logic        trk_nonzero;
  logic        on_side_two;
  logic [5:0]  side_trk;
  logic        side_ok;
  logic [23:0] side_off;
  logic [23:0] sec_off;
  logic [23:0] d81_off;
  logic [23:0] hd_off;
  logic        ok;
  logic [23:0] off;

  // Per-side zoned lookup and the linear layouts.
  always_comb begin
    trk         = req.track_number;
    sec         = req.sector_number;
    trk_m1      = trk - 8'd1;
    trk_nonzero = (trk != 8'd0);
    on_side_two = (trk > 8'(diso_pkg::SIDE_TRACKS));
    side_trk    = on_side_two ? 6'(trk - 8'(diso_pkg::SIDE_TRACKS)) : 6'(trk);
    side_ok     = (side_trk != 6'd0) && (side_trk <= 6'(diso_pkg::SIDE_TRACKS)) &&
                  (sec < 8'(diso_pkg::zone_sectors(side_trk)));
    sec_off     = 24'({sec, 8'h00});
    side_off    = 24'(diso_pkg::zone_start(side_trk - 6'd1)) + sec_off;
    d81_off     = 24'(trk_m1) * 24'(diso_pkg::D81_TRACK_BYTES) + sec_off;
    hd_off      = 24'(diso_pkg::SECTOR_BYTES) + {trk_m1, 16'h0000} + sec_off;
  end

  // Image kind decode; the offset reads zero whenever the sector does not exist.
  always_comb begin
    ok  = 1'b0;
    off = '0;
    unique case (media_kind)
      diso_pkg::MEDIA_ZONED_SINGLE: begin
        ok  = trk_nonzero && !on_side_two && side_ok;
        off = side_off;
      end
      diso_pkg::MEDIA_ZONED_DOUBLE: begin
        if (!on_side_two) begin
          ok  = trk_nonzero && side_ok;
          off = side_off;
        end else if (trk <= 8'(2 * diso_pkg::SIDE_TRACKS)) begin
          ok  = side_ok;
          off = side_off + 24'(diso_pkg::SIDE_TWO_BASE);
        end
      end
      diso_pkg::MEDIA_LINEAR_DISK: begin
        ok  = trk_nonzero;
        off = d81_off;
      end
      diso_pkg::MEDIA_HARD_DISK: begin
        ok  = trk_nonzero;
        off = hd_off;
      end
      default: begin
        ok  = 1'b0;
        off = '0;
      end
    endcase
    res.offset_valid = ok;
    res.byte_offset  = ok ? off : 24'd0;
  end

endmodule

`default_nettype wire

FILE: hdl/disk_image_sector_offset_core.sv
// Top level of the disk image sector offset core: input stage, resolver, result stage.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_ready   in_track_number, in_sector_number
//   out      source     out_valid / out_ready out_offset_valid, out_byte_offset
//   cfg      sink       cfg_wr_en             cfg_wr_data (image kind)
//
// One result per request; a request transfers in every cycle when out_ready is high.
// A request passes through the input register, then the resolver into the result register.
// rst_n is synchronous and active low; it empties both stages and sets the image kind to zoned single.
// A stalled result holds in the result register while the input register still takes
// one more request; in_ready drops once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module disk_image_sector_offset_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_track_number,
  input  wire logic [7:0]  in_sector_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_offset_valid,
  output logic [23:0]      out_byte_offset,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data
);

  logic [2:0]        media_kind_r;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  diso_pkg::req_t    s1_req_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  diso_pkg::result_t out_res_r;
  diso_pkg::result_t calc_res;
  logic              s2_ready;
  logic              s1_ready;
  logic              s1_move;

  // Image kind register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media_kind_r <= diso_pkg::MEDIA_ZONED_SINGLE;
    end else if (cfg_wr_en) begin
      media_kind_r <= cfg_wr_data;
    end
  end

  // Stage flow control: each stage loads when it is empty or its content moves on.
  always_comb begin
    s2_ready      = !out_valid_r || out_ready;
    s1_ready      = !s1_valid_r || s2_ready;
    s1_move       = s1_valid_r && s2_ready;
    s1_valid_nxt  = in_valid ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    if (!s1_ready) begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_req_r.track_number  <= in_track_number;
      s1_req_r.sector_number <= in_sector_number;
    end
  end

  // Offset resolver between the two registers.
  diso_calc u_calc (
    .req        (s1_req_r),
    .media_kind (media_kind_r),
    .res        (calc_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= calc_res;
    end
  end

  assign in_ready         = s1_ready;
  assign out_valid        = out_valid_r;
  assign out_offset_valid = out_res_r.offset_valid;
  assign out_byte_offset  = out_res_r.byte_offset;

endmodule

`default_nettype wire

FILE: hdl/diso_checker.sv
// Port-level checker for the sector offset core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "disk_image_sector_offset_core_macros.svh"

module diso_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_offset_valid,
  input wire logic [23:0] out_byte_offset
);

  // A stalled result stays offered and unchanged.
  `DISO_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_offset_valid) && $stable(out_byte_offset), "stalled result changed")

  // A sector that does not exist reports offset zero.
  `DISO_ASSERT_NOW(a_invalid_zero, clk, !rst_n, out_valid && !out_offset_valid, out_byte_offset == 24'd0, "invalid result with nonzero offset")

  // Every valid offset starts on a sector boundary.
  `DISO_ASSERT_NOW(a_sector_align, clk, !rst_n, out_valid && out_offset_valid, out_byte_offset[7:0] == 8'd0, "offset not sector aligned")

  // Reset empties the result stage.
  `DISO_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid, "result offered right after reset")

endmodule

bind disk_image_sector_offset_core diso_checker u_diso_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_offset_valid (out_offset_valid),
  .out_byte_offset  (out_byte_offset)
);

`default_nettype wire

FILE: tb/sv/disk_image_sector_offset_checker.sv
// Result checker for the disk image sector offset core: predicts each lookup and compares.
`timescale 1ns / 1ps

module disk_image_sector_offset_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_track_number,
  input  wire logic [7:0]  in_sector_number,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_offset_valid,
  input  wire logic [23:0] out_byte_offset,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  output int unsigned      results_pending,
  output int unsigned      mismatch_count
);

  localparam int unsigned HD_TRACK_BYTES = 65536;

  // Image kind as the block should hold it, tracked from the write port.
  logic [2:0]        media_kind;
  // Predicted results, oldest first.
  diso_pkg::result_t pending_offsets[$];

  // Print one line per mismatch and count every one.
  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sector lookup within one zoned side of 35 tracks. Track starts are summed
  // from the zone sizes: 21, 19, 18 and 17 sectors per track.
  function automatic diso_pkg::result_t side_offset(input int trk, input int sec);
    diso_pkg::result_t r;
    int                per_track;
    int                first_sector;
    r = '0;
    per_track = 0;
    first_sector = 0;
    if (trk >= 1 && trk <= int'(diso_pkg::SIDE_TRACKS)) begin
      if (trk <= 17) begin
        per_track = 21;
        first_sector = (trk - 1) * 21;
      end else if (trk <= 24) begin
        per_track = 19;
        first_sector = 17 * 21 + (trk - 18) * 19;
      end else if (trk <= 30) begin
        per_track = 18;
        first_sector = 17 * 21 + 7 * 19 + (trk - 25) * 18;
      end else begin
        per_track = 17;
        first_sector = 17 * 21 + 7 * 19 + 6 * 18 + (trk - 31) * 17;
      end
      if (sec < per_track) begin
        r.offset_valid = 1'b1;
        r.byte_offset  = 24'((first_sector + sec) * int'(diso_pkg::SECTOR_BYTES));
      end
    end
    return r;
  endfunction

  // Expected result of one lookup for the given image kind.
  function automatic diso_pkg::result_t resolve_offset(input logic [2:0] kind,
                                                       input logic [7:0] trk,
                                                       input logic [7:0] sec);
    diso_pkg::result_t r;
    int                t;
    int                s;
    r = '0;
    t = int'(trk);
    s = int'(sec);
    if (t != 0) begin
      case (kind)
        diso_pkg::MEDIA_ZONED_SINGLE: begin
          r = side_offset(t, s);
        end
        diso_pkg::MEDIA_ZONED_DOUBLE: begin
          // Second side holds tracks 36 to 70; anything higher does not exist.
          if (t <= int'(diso_pkg::SIDE_TRACKS)) begin
            r = side_offset(t, s);
          end else if (t <= 2 * int'(diso_pkg::SIDE_TRACKS)) begin
            r = side_offset(t - int'(diso_pkg::SIDE_TRACKS), s);
            if (r.offset_valid) begin
              r.byte_offset = r.byte_offset + 24'(diso_pkg::SIDE_TWO_BASE);
            end
          end
        end
        diso_pkg::MEDIA_LINEAR_DISK: begin
          r.offset_valid = 1'b1;
          r.byte_offset  = 24'((t - 1) * int'(diso_pkg::D81_TRACK_BYTES)
                               + s * int'(diso_pkg::SECTOR_BYTES));
        end
        diso_pkg::MEDIA_HARD_DISK: begin
          r.offset_valid = 1'b1;
          r.byte_offset  = 24'(int'(diso_pkg::SECTOR_BYTES) + (t - 1) * int'(HD_TRACK_BYTES)
                               + s * int'(diso_pkg::SECTOR_BYTES));
        end
        default: begin
          r = '0;
        end
      endcase
    end
    return r;
  endfunction

  // Follow both channels and the register write at every clock edge.
  always @(posedge clk) begin
    diso_pkg::result_t want;
    if (!rst_n) begin
      media_kind = diso_pkg::MEDIA_ZONED_SINGLE;
      pending_offsets.delete();
      mismatch_count = 0;
      results_pending <= 0;
    end else begin
      // A result transfer is matched against the oldest prediction.
      if (out_valid && out_ready) begin
        if (pending_offsets.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: offset_valid=%0b byte_offset=0x%06h",
                                  out_offset_valid, out_byte_offset));
        end else begin
          want = pending_offsets.pop_front();
          if (out_offset_valid !== want.offset_valid) begin
            flag_mismatch($sformatf("offset_valid: got %0b, expected %0b",
                                    out_offset_valid, want.offset_valid));
          end
          if (out_byte_offset !== want.byte_offset) begin
            flag_mismatch($sformatf("byte_offset: got 0x%06h, expected 0x%06h",
                                    out_byte_offset, want.byte_offset));
          end
        end
      end
      // A request transfer is predicted with the image kind held before this edge.
      if (in_valid && in_ready) begin
        pending_offsets.push_back(resolve_offset(media_kind, in_track_number,
                                                 in_sector_number));
      end
      if (cfg_wr_en) begin
        media_kind = cfg_wr_data;
      end
      results_pending <= pending_offsets.size();
    end
  end

endmodule

FILE: tb/sv/tb_disk_image_sector_offset_core.sv
// Testbench top for the disk image sector offset core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_disk_image_sector_offset_core;

  // Image kinds with no meaning; the block must reject every lookup.
  localparam logic [2:0]  MEDIA_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0]  MEDIA_UNKNOWN_LAST  = 3'd7;
  localparam int unsigned CYCLE_LIMIT         = 200000;
  localparam int unsigned LOOKUPS_PER_KIND    = 58;
  localparam int unsigned DRAIN_CYCLES        = 4;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic [7:0]  in_track_number  = '0;
  logic [7:0]  in_sector_number = '0;
  logic        out_ready        = 1'b0;
  logic        cfg_wr_en        = 1'b0;
  logic [2:0]  cfg_wr_data      = '0;
  wire logic   in_ready;
  wire logic   out_valid;
  wire logic   out_offset_valid;
  wire logic [23:0] out_byte_offset;

  int unsigned results_pending;
  int unsigned mismatch_count;
  int unsigned cycle_count  = 0;
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;

  // Idle percentages per random phase: receiver first, then sender, then none.
  int unsigned tx_gap_plan[3]   = '{20, 55, 0};
  int unsigned rx_stall_plan[3] = '{55, 20, 0};

  disk_image_sector_offset_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_track_number  (in_track_number),
    .in_sector_number (in_sector_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_offset_valid (out_offset_valid),
    .out_byte_offset  (out_byte_offset),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  disk_image_sector_offset_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_track_number  (in_track_number),
    .in_sector_number (in_sector_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_offset_valid (out_offset_valid),
    .out_byte_offset  (out_byte_offset),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .results_pending  (results_pending),
    .mismatch_count   (mismatch_count)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Offer one lookup, after a random number of idle cycles, and hold it until its transfer.
  task automatic send_lookup(input logic [7:0] trk, input logic [7:0] sec);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_track_number  <= trk;
    in_sector_number <= sec;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering lookups and wait until every predicted result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Write the image kind once the core is empty.
  task automatic set_media_kind(input logic [2:0] kind);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= kind;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Main stimulus.
  initial begin
    logic [7:0] trk;
    logic [7:0] sec;
    int         roll;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zone boundaries, track zero and the track limits of the zoned layout.
    set_media_kind(diso_pkg::MEDIA_ZONED_SINGLE);
    send_lookup(8'd0, 8'd0);
    send_lookup(8'd1, 8'd0);
    send_lookup(8'd1, 8'd20);
    send_lookup(8'd1, 8'd21);
    send_lookup(8'd17, 8'd20);
    send_lookup(8'd18, 8'd0);
    send_lookup(8'd18, 8'd19);
    send_lookup(8'd24, 8'd18);
    send_lookup(8'd25, 8'd18);
    send_lookup(8'd30, 8'd17);
    send_lookup(8'd31, 8'd17);
    send_lookup(8'd35, 8'd16);
    send_lookup(8'd36, 8'd0);

    // Second side: last track of side one, first and last of side two, beyond it.
    set_media_kind(diso_pkg::MEDIA_ZONED_DOUBLE);
    send_lookup(8'd35, 8'd16);
    send_lookup(8'd36, 8'd0);
    send_lookup(8'd70, 8'd16);
    send_lookup(8'd70, 8'd17);
    send_lookup(8'd71, 8'd0);

    // Linear layouts at their corners.
    set_media_kind(diso_pkg::MEDIA_LINEAR_DISK);
    send_lookup(8'd255, 8'd255);
    send_lookup(8'd0, 8'd255);
    set_media_kind(diso_pkg::MEDIA_HARD_DISK);
    send_lookup(8'd255, 8'd255);

    // Kinds that never resolve.
    set_media_kind(diso_pkg::MEDIA_SECTORLESS);
    send_lookup(8'd1, 8'd0);
    set_media_kind(MEDIA_UNKNOWN_FIRST);
    send_lookup(8'd1, 8'd0);
    set_media_kind(MEDIA_UNKNOWN_LAST);
    send_lookup(8'd255, 8'd255);

    // Random lookups for every image kind under each flow control phase.
    for (int phase = 0; phase < 3; phase++) begin
      tx_gap_pct   = tx_gap_plan[phase];
      rx_stall_pct = rx_stall_plan[phase];
      for (int k = diso_pkg::MEDIA_ZONED_SINGLE; k <= MEDIA_UNKNOWN_LAST; k++) begin
        set_media_kind(3'(k));
        for (int n = 0; n < LOOKUPS_PER_KIND; n++) begin
          roll = $urandom_range(0, 99);
          trk  = 8'($urandom_range(0, 255));
          sec  = 8'($urandom_range(0, 255));
          // Most lookups on the zoned layouts land near real tracks and sectors.
          if (roll < 70 && 3'(k) == diso_pkg::MEDIA_ZONED_SINGLE) begin
            trk = 8'($urandom_range(1, 35));
            sec = 8'($urandom_range(0, 21));
          end else if (roll < 70 && 3'(k) == diso_pkg::MEDIA_ZONED_DOUBLE) begin
            trk = 8'($urandom_range(1, 71));
            sec = 8'($urandom_range(0, 21));
          end
          send_lookup(trk, sec);
        end
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
